@@ hw/rtl/ptlm_pkg.sv @@
package ptlm_pkg;

  // Default build values
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF    = 20;

  // Field widths
  localparam int ELAPSED_W = 20;
  localparam int AVG_W     = 24;
  localparam int MAX_W     = 20;
  localparam int LOAD_W    = 24;
  localparam int DROP_W    = 32;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 104;

  // Register widths
  localparam int SR_W       = 19;
  localparam int BS_W       = 14;
  localparam int FRAC_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // Available time: buffer_size * 1e6 fits in 34 bits
  localparam int AVAIL_W = 34;
  localparam logic [AVAIL_W-1:0] US_PER_S = AVAIL_W'(1000000);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DROPOUT_FRACTION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_FRACTION = 2'd3;

  // Register reset values
  localparam logic [SR_W-1:0]   SR_RESET    = 19'd48000;
  localparam logic [BS_W-1:0]   BS_RESET    = 14'd512;
  localparam logic [FRAC_W-1:0] DFRAC_RESET = 10'd256;
  localparam logic [FRAC_W-1:0] WFRAC_RESET = 10'd205;

  // Action codes
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Saturation limit of the 24-bit avg (Q4) and load (Q8) outputs
  localparam logic [AVG_W-1:0] Q24_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    DIV_AVAIL,
    DIV_AVG,
    DIV_LOAD
  } div_sel_t;

  typedef struct packed {
    logic     take;
    logic     clear;
    logic     wr;
    logic     scan_start;
    logic     scan_step;
    logic     div_start;
    logic     div_take;
    div_sel_t div_sel;
    logic     avail_clr;
    logic     mul;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic avail_off;
    logic avail_zero;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/processing_time_load_monitor.sv @@
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: elapsed_us; tuser: action
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: avg, max, load, dropouts, risk
// cfg       in         cfg_we                        cfg_addr, cfg_wdata
//
// A record walks the n filled slots of the window on the single read port, then one shared
// bit-serial divider of D bits (max(SUM_W+15, 34), 42 at the default build) runs up to three
// times; a divide is skipped for zero available time.
// rst is synchronous; the window needs no clearing pass.
// s_axis_tready is high only when idle, so a new item may be taken while a result still
// waits in the output register; the next result then holds until that one is handed over.
module processing_time_load_monitor #(
  parameter int WINDOW_DEPTH = ptlm_pkg::WINDOW_DEPTH_DEF,
  parameter int TIME_BITS    = ptlm_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ptlm_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [19:0] elapsed_us
  input  logic                                s_axis_tuser,  // [0] action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [23:0] avg_time_q4, [43:24] max_time_us, [67:44] load_percent_q8,
  // [99:68] dropout_total, [100] risk_flag
  output logic [ptlm_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [ptlm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [ptlm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ptlm_pkg::cmd_t    cmd;
  ptlm_pkg::status_t status;

  ptlm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ptlm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .elapsed_in (s_axis_tdata[ptlm_pkg::ELAPSED_W-1:0]),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_data   (m_axis_tdata)
  );

endmodule

@@ hw/rtl/ptlm_ram.sv @@
module ptlm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ptlm_div.sv @@
module ptlm_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 41
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign shifted = {rem, quo[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        rem   <= '0;
        den_r <= den;
        quo   <= num;
      end else if (busy) begin
        rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/ptlm_ctrl.sv @@
module ptlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  input  ptlm_pkg::status_t status,
  output ptlm_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    CLR,
    WRITE,
    SCAN,
    AVAIL_GO,
    AVAIL_WAIT,
    AVG_GO,
    AVG_WAIT,
    MUL,
    LOAD_GO,
    LOAD_WAIT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.div_sel = ptlm_pkg::DIV_AVAIL;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = (in_action == ptlm_pkg::ACT_CLEAR) ? CLR : WRITE;
        end
      end
      CLR: begin
        if (status.out_free) begin
          cmd.clear  = 1'b1;
          state_next = IDLE;
        end
      end
      WRITE: begin
        cmd.wr         = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = SCAN;
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = AVAIL_GO;
        end
      end
      AVAIL_GO: begin
        if (status.avail_off) begin
          cmd.avail_clr = 1'b1;
          state_next    = AVG_GO;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = AVAIL_WAIT;
        end
      end
      AVAIL_WAIT: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = AVG_GO;
        end
      end
      AVG_GO: begin
        cmd.div_sel   = ptlm_pkg::DIV_AVG;
        cmd.div_start = 1'b1;
        state_next    = AVG_WAIT;
      end
      AVG_WAIT: begin
        cmd.div_sel = ptlm_pkg::DIV_AVG;
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = MUL;
        end
      end
      MUL: begin
        cmd.mul    = 1'b1;
        state_next = LOAD_GO;
      end
      LOAD_GO: begin
        cmd.div_sel = ptlm_pkg::DIV_LOAD;
        if (status.avail_zero) begin
          state_next = FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = LOAD_WAIT;
        end
      end
      LOAD_WAIT: begin
        cmd.div_sel = ptlm_pkg::DIV_LOAD;
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = FINISH;
        end
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/ptlm_dp.sv @@
module ptlm_dp #(
  parameter int WINDOW_DEPTH = ptlm_pkg::WINDOW_DEPTH_DEF,
  parameter int TIME_BITS    = ptlm_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ptlm_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [ptlm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [ptlm_pkg::ELAPSED_W-1:0]      elapsed_in,
  input  ptlm_pkg::cmd_t                      cmd,
  output ptlm_pkg::status_t                   status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ptlm_pkg::M_TDATA_W-1:0]      out_data
);

  localparam int ELW    = (TIME_BITS < ptlm_pkg::ELAPSED_W) ? TIME_BITS : ptlm_pkg::ELAPSED_W;
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = ELW + CNT_W;
  localparam int NUM_W  = (SUM_W + 15 > ptlm_pkg::AVAIL_W) ? SUM_W + 15 : ptlm_pkg::AVAIL_W;
  localparam int DEN_W  = CNT_W + ptlm_pkg::AVAIL_W;
  localparam int DRP_W  = ptlm_pkg::AVAIL_W + ptlm_pkg::FRAC_W;
  localparam int RSK_W  = DEN_W + ptlm_pkg::FRAC_W;

  // Configuration
  logic [ptlm_pkg::SR_W-1:0]   sample_rate;
  logic [ptlm_pkg::BS_W-1:0]   buffer_size;
  logic [ptlm_pkg::FRAC_W-1:0] dropout_fraction;
  logic [ptlm_pkg::FRAC_W-1:0] warning_fraction;

  // Window bookkeeping and scan
  logic [ELW-1:0]   elapsed;
  logic [IDX_W-1:0] write_slot;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_cnt;
  logic             scan_pend;
  logic [SUM_W-1:0] sum;
  logic [ELW-1:0]   mx;
  logic [ELW-1:0]   rdata;

  // Arithmetic
  logic [ptlm_pkg::AVAIL_W-1:0] avail;
  logic [ptlm_pkg::AVG_W-1:0]   avg;
  logic [NUM_W-1:0]             load_num;
  logic [DEN_W-1:0]             load_den;
  logic                         drop_hit;
  logic [ptlm_pkg::LOAD_W-1:0]  load_q;

  // Held statistics
  logic [ptlm_pkg::LOAD_W-1:0] held_load;
  logic [ptlm_pkg::DROP_W-1:0] dropout_counter;
  logic                        risk_state;
  logic [ptlm_pkg::LOAD_W-1:0] held_load_next;
  logic [ptlm_pkg::DROP_W-1:0] dropout_counter_next;
  logic                        risk_state_next;

  // Divider
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [DRP_W-1:0] drop_lhs;
  logic [DRP_W-1:0] drop_rhs;
  logic [RSK_W-1:0] risk_lhs;
  logic [RSK_W-1:0] risk_rhs;

  ptlm_ram #(
    .WIDTH (ELW),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (write_slot),
    .wdata (elapsed),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Pick the operands of the shared divider
  always_comb begin
    case (cmd.div_sel)
      ptlm_pkg::DIV_AVAIL: begin
        div_num = NUM_W'(ptlm_pkg::AVAIL_W'(buffer_size) * ptlm_pkg::US_PER_S);
        div_den = DEN_W'(sample_rate);
      end
      ptlm_pkg::DIV_AVG: begin
        div_num = NUM_W'(sum) << 4;
        div_den = DEN_W'(fill_count);
      end
      ptlm_pkg::DIV_LOAD: begin
        div_num = load_num;
        div_den = load_den;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  ptlm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Threshold products
  assign drop_lhs = DRP_W'(elapsed) << 8;
  assign drop_rhs = DRP_W'(avail) * DRP_W'(dropout_fraction);
  assign risk_lhs = RSK_W'(sum) << 8;
  assign risk_rhs = RSK_W'(warning_fraction) * RSK_W'(load_den);

  // Next held statistics: only move when time is available
  always_comb begin
    held_load_next       = held_load;
    dropout_counter_next = dropout_counter;
    risk_state_next      = risk_state;
    if (avail != '0) begin
      held_load_next  = load_q;
      risk_state_next = risk_lhs > risk_rhs;
      if (drop_hit && (dropout_counter != '1)) begin
        dropout_counter_next = dropout_counter + 1'b1;
      end
    end
  end

  assign status.scan_done  = (scan_cnt == fill_count) && !scan_pend;
  assign status.div_done   = div_done;
  assign status.avail_off  = (sample_rate == '0) || (buffer_size == '0);
  assign status.avail_zero = (avail == '0);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate      <= ptlm_pkg::SR_RESET;
      buffer_size      <= ptlm_pkg::BS_RESET;
      dropout_fraction <= ptlm_pkg::DFRAC_RESET;
      warning_fraction <= ptlm_pkg::WFRAC_RESET;
      write_slot       <= '0;
      fill_count       <= '0;
      scan_cnt         <= '0;
      scan_pend        <= 1'b0;
      held_load        <= '0;
      dropout_counter  <= '0;
      risk_state       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      // Register writes
      if (cfg_we) begin
        case (cfg_addr)
          ptlm_pkg::REG_SAMPLE_RATE:      sample_rate      <= cfg_wdata[ptlm_pkg::SR_W-1:0];
          ptlm_pkg::REG_BUFFER_SIZE:      buffer_size      <= cfg_wdata[ptlm_pkg::BS_W-1:0];
          ptlm_pkg::REG_DROPOUT_FRACTION: dropout_fraction <= cfg_wdata[ptlm_pkg::FRAC_W-1:0];
          ptlm_pkg::REG_WARNING_FRACTION: warning_fraction <= cfg_wdata[ptlm_pkg::FRAC_W-1:0];
          default: begin
          end
        endcase
      end

      // Latch the measurement
      if (cmd.take) begin
        elapsed <= elapsed_in[ELW-1:0];
      end

      // Advance the circular window
      if (cmd.wr) begin
        write_slot <= (write_slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (fill_count != CNT_W'(WINDOW_DEPTH)) begin
          fill_count <= fill_count + 1'b1;
        end
      end

      // Walk the filled slots, one read per cycle
      if (cmd.scan_start) begin
        scan_cnt  <= '0;
        scan_pend <= 1'b0;
        sum       <= '0;
        mx        <= '0;
      end else if (cmd.scan_step) begin
        scan_pend <= scan_cnt < fill_count;
        if (scan_cnt < fill_count) begin
          scan_cnt <= scan_cnt + 1'b1;
        end
        if (scan_pend) begin
          sum <= sum + SUM_W'(rdata);
          if (rdata > mx) begin
            mx <= rdata;
          end
        end
      end

      // Collect quotients
      if (cmd.avail_clr) begin
        avail <= '0;
      end
      if (cmd.div_take) begin
        case (cmd.div_sel)
          ptlm_pkg::DIV_AVAIL: avail <= div_quo[ptlm_pkg::AVAIL_W-1:0];
          ptlm_pkg::DIV_AVG: begin
            avg <= (div_quo > NUM_W'(ptlm_pkg::Q24_MAX)) ? ptlm_pkg::Q24_MAX
                                                          : div_quo[ptlm_pkg::AVG_W-1:0];
          end
          ptlm_pkg::DIV_LOAD: begin
            load_q <= (div_quo > NUM_W'(ptlm_pkg::Q24_MAX)) ? ptlm_pkg::Q24_MAX
                                                             : div_quo[ptlm_pkg::LOAD_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // Form load operands and dropout test
      if (cmd.mul) begin
        load_num <= NUM_W'(sum) * NUM_W'(25600);
        load_den <= DEN_W'(fill_count) * DEN_W'(avail);
        drop_hit <= drop_lhs > drop_rhs;
      end

      // Hand the result, or the zeros of a clear, to the output register; a clear also empties the window
      if (cmd.finish) begin
        held_load       <= held_load_next;
        dropout_counter <= dropout_counter_next;
        risk_state      <= risk_state_next;
        out_valid       <= 1'b1;
        out_data        <= {3'b000, risk_state_next, dropout_counter_next, held_load_next,
                            ptlm_pkg::MAX_W'(mx), avg};
      end else if (cmd.clear) begin
        write_slot      <= '0;
        fill_count      <= '0;
        held_load       <= '0;
        dropout_counter <= '0;
        risk_state      <= 1'b0;
        out_valid       <= 1'b1;
        out_data        <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;

  typedef struct packed {
    logic [23:0] avg;
    logic [19:0] peak;
    logic [23:0] load;
    logic [31:0] drops;
    logic        risk;
  } stats_t;

  // Window model of the monitor plus the queue of stats still to come out
  class load_monitor_sb;
    logic [19:0] window_us[64];
    int unsigned slot;
    int unsigned fill;
    logic [23:0] load_hold;
    logic [31:0] drop_cnt;
    bit          risk_hold;
    logic [18:0] rate_hz;
    logic [13:0] buf_len;
    logic [9:0]  drop_frac;
    logic [9:0]  warn_frac;
    stats_t      stats_q[$];
    int          errors;

    function void wipe();
      foreach (window_us[i]) window_us[i] = '0;
      slot = 0;
      fill = 0;
      load_hold = '0;
      drop_cnt = '0;
      risk_hold = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [18:0] val);
      case (idx)
        ptlm_pkg::REG_SAMPLE_RATE:      rate_hz = val;
        ptlm_pkg::REG_BUFFER_SIZE:      buf_len = val[13:0];
        ptlm_pkg::REG_DROPOUT_FRACTION: drop_frac = val[9:0];
        ptlm_pkg::REG_WARNING_FRACTION: warn_frac = val[9:0];
        default: ;
      endcase
    endfunction

    function longint unsigned avail_us();
      if (rate_hz == 0 || buf_len == 0) return 0;
      return (longint'(buf_len) * 64'd1000000) / longint'(rate_hz);
    endfunction

    // Predict the stats that one accepted transfer produces
    function void note_input(logic act, logic [19:0] el);
      longint unsigned sum, peak, avg, avail, den, ld;
      stats_t s;
      if (act == ptlm_pkg::ACT_CLEAR) begin
        wipe();
        stats_q.push_back('0);
        return;
      end
      window_us[slot] = el;
      slot = (slot + 1) % 64;
      if (fill < 64) fill++;
      sum = 0;
      peak = 0;
      for (int i = 0; i < fill; i++) begin
        sum += window_us[i];
        if (window_us[i] > peak) peak = window_us[i];
      end
      avg = (sum * 16) / fill;
      if (avg > 64'hFFFFFF) avg = 64'hFFFFFF;
      avail = avail_us();
      if (avail != 0) begin
        den = fill * avail;
        ld = (sum * 25600) / den;
        load_hold = (ld > 64'hFFFFFF) ? 24'hFFFFFF : ld[23:0];
        if (longint'(el) * 256 > avail * drop_frac && drop_cnt != 32'hFFFFFFFF)
          drop_cnt++;
        risk_hold = (sum * 256 > warn_frac * den);
      end
      s.avg = avg[23:0];
      s.peak = peak[19:0];
      s.load = load_hold;
      s.drops = drop_cnt;
      s.risk = risk_hold;
      stats_q.push_back(s);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(logic [ptlm_pkg::M_TDATA_W-1:0] d);
      stats_t e;
      if (stats_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = stats_q.pop_front();
      if (d[23:0] !== e.avg) begin
        $display("%0t avg_time_q4 exp %h got %h", $time, e.avg, d[23:0]);
        errors++;
      end
      if (d[43:24] !== e.peak) begin
        $display("%0t max_time_us exp %h got %h", $time, e.peak, d[43:24]);
        errors++;
      end
      if (d[67:44] !== e.load) begin
        $display("%0t load_percent_q8 exp %h got %h", $time, e.load, d[67:44]);
        errors++;
      end
      if (d[99:68] !== e.drops) begin
        $display("%0t dropout_total exp %h got %h", $time, e.drops, d[99:68]);
        errors++;
      end
      if (d[100] !== e.risk) begin
        $display("%0t risk_flag exp %b got %b", $time, e.risk, d[100]);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [ptlm_pkg::S_TDATA_W-1:0]   s_axis_tdata;
  logic                             s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [ptlm_pkg::M_TDATA_W-1:0]   m_axis_tdata;
  logic                             cfg_we;
  logic [ptlm_pkg::CFG_IDX_W-1:0]   cfg_addr;
  logic [ptlm_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  load_monitor_sb sb;
  bit             no_idle;
  int             results_seen;

  processing_time_load_monitor dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("processing_time_load_monitor regression: fail");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_item(logic act, logic [19:0] el);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 0;
    end
    @(negedge clk);
    s_axis_tvalid = 1;
    s_axis_tuser = act;
    s_axis_tdata = {4'b0, el};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, el);
  endtask

  // Hold the sender until every predicted result has come out
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (sb.stats_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [18:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [18:0] sr, logic [13:0] bs, logic [9:0] df, logic [9:0] wf);
    drain();
    write_reg(ptlm_pkg::REG_SAMPLE_RATE, sr);
    write_reg(ptlm_pkg::REG_BUFFER_SIZE, {5'b0, bs});
    write_reg(ptlm_pkg::REG_DROPOUT_FRACTION, {9'b0, df});
    write_reg(ptlm_pkg::REG_WARNING_FRACTION, {9'b0, wf});
  endtask

  // Times near the available time, with some full-range values and clears
  task automatic random_items(int count);
    longint unsigned avail;
    logic [19:0] el;
    avail = sb.avail_us();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(ptlm_pkg::ACT_CLEAR, 20'($urandom));
        continue;
      end
      if (avail == 0 || $urandom_range(0, 3) == 0) el = 20'($urandom);
      else if (avail * 2 > 20'hFFFFF) el = 20'($urandom);
      else el = 20'($urandom_range(0, 32'(avail * 2 + 8)));
      send_item(ptlm_pkg::ACT_RECORD, el);
    end
  endtask

  // Output side: random stalls plus one long hold-off
  initial begin
    int stall;
    bit held;
    stall = 0;
    held = 0;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (!held && results_seen == 150) begin
        held = 1;
        m_axis_tready = 0;
        repeat (600) @(negedge clk);
      end
      if (stall > 0) begin
        m_axis_tready = 0;
        stall--;
      end else begin
        m_axis_tready = 1;
      end
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        results_seen++;
        stall = pick_gap();
      end
    end
  end

  initial begin
    logic [18:0] rates[6];
    sb = new();
    sb.wipe();
    sb.rate_hz = ptlm_pkg::SR_RESET;
    sb.buf_len = ptlm_pkg::BS_RESET;
    sb.drop_frac = ptlm_pkg::DFRAC_RESET;
    sb.warn_frac = ptlm_pkg::WFRAC_RESET;
    rates = '{19'd8000, 19'd44100, 19'd48000, 19'd96000, 19'd192000, 19'd384000};
    results_seen = 0;
    no_idle = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset settings, field extremes, threshold edges, clears
    send_item(ptlm_pkg::ACT_RECORD, 20'd0);
    send_item(ptlm_pkg::ACT_RECORD, 20'hFFFFF);
    send_item(ptlm_pkg::ACT_RECORD, 20'd1);
    send_item(ptlm_pkg::ACT_RECORD, 20'd10666);
    send_item(ptlm_pkg::ACT_RECORD, 20'd10667);
    send_item(ptlm_pkg::ACT_CLEAR, 20'hFFFFF);
    send_item(ptlm_pkg::ACT_CLEAR, 20'd0);
    send_item(ptlm_pkg::ACT_RECORD, 20'd10666);
    // Tiny available time: load saturates
    set_config(19'h7FFFF, 14'd1, 10'h3FF, 10'h3FF);
    send_item(ptlm_pkg::ACT_RECORD, 20'hFFFFF);
    send_item(ptlm_pkg::ACT_RECORD, 20'd0);
    send_item(ptlm_pkg::ACT_RECORD, 20'd1);
    // Huge available time, zero fractions
    set_config(19'd1, 14'h3FFF, 10'd0, 10'd0);
    send_item(ptlm_pkg::ACT_RECORD, 20'd0);
    send_item(ptlm_pkg::ACT_RECORD, 20'hFFFFF);
    // Tracking disabled by each setting: held values stay
    set_config(19'd0, 14'd512, 10'd256, 10'd205);
    send_item(ptlm_pkg::ACT_RECORD, 20'hFFFFF);
    send_item(ptlm_pkg::ACT_RECORD, 20'd5);
    set_config(19'd48000, 14'd0, 10'd256, 10'd205);
    send_item(ptlm_pkg::ACT_RECORD, 20'h80000);
    send_item(ptlm_pkg::ACT_CLEAR, 20'd7);
    send_item(ptlm_pkg::ACT_RECORD, 20'd3);

    // Random phases; the receiver hold-off lands early in these
    for (int ph = 0; ph < 14; ph++) begin
      logic [18:0] sr;
      logic [13:0] bs;
      int pick;
      pick = $urandom_range(0, 9);
      sr = (pick < 6) ? rates[$urandom_range(0, 5)] : (pick < 9 ? 19'($urandom) : 19'd0);
      pick = $urandom_range(0, 9);
      bs = (pick < 6) ? 14'(32 << $urandom_range(0, 8)) : (pick < 9 ? 14'($urandom) : 14'd0);
      no_idle = (ph % 4 == 3);
      set_config(sr, bs, 10'($urandom), 10'($urandom_range(100, 300)));
      random_items(50);
      // Sender pause until all results are out, then carry on with the same setup
      drain();
      random_items(50);
    end
    no_idle = 0;

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.stats_q.size() == 0)
      $display("processing_time_load_monitor regression: pass");
    else
      $display("processing_time_load_monitor regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ptlm_pkg.sv
hw/rtl/ptlm_ram.sv
hw/rtl/ptlm_div.sv
hw/rtl/ptlm_ctrl.sv
hw/rtl/ptlm_dp.sv
hw/rtl/processing_time_load_monitor.sv
sim/tb.sv
